/* design/lzwcd_pkg.sv */
// Shared types and constants for the LZSS window copy decoder.
// No dependencies; imported by the interfaces and all design modules.
package lzwcd_pkg;

   localparam int POS_W  = 14;
   localparam int LEN_W  = 9;
   localparam int BYTE_W = 8;
   localparam int LANES  = 8;
   localparam int LANE_W = 3;
   localparam int OUT_W  = LANES * BYTE_W;
   localparam int CNT_W  = 4;

   localparam logic ACT_LITERAL = 1'b0;
   localparam logic ACT_MATCH   = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MATCH,
      ST_WRITEBACK
   } state_type;

   // byte lanes below cnt set to all ones
   function automatic logic [OUT_W-1:0] lane_mask(input logic [CNT_W-1:0] cnt);
      logic [OUT_W-1:0] m;
      m = '0;
      for (int i = 0; i < LANES; i++) begin
         if (CNT_W'(i) < cnt) m[i*BYTE_W +: BYTE_W] = '1;
      end
      return m;
   endfunction

endpackage

/* design/lzwcd_if.sv */
// Valid/ready channel interfaces for token beats and result beats.
// Depends on lzwcd_pkg for field widths.
interface lzwcd_req_if import lzwcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [BYTE_W-1:0] literal_byte;
   logic [POS_W-1:0]  match_pos;
   logic [LEN_W-1:0]  match_len;

   modport source (output valid, action, literal_byte, match_pos, match_len, input ready);
   modport sink   (input valid, action, literal_byte, match_pos, match_len, output ready);
endinterface

interface lzwcd_rsp_if import lzwcd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] out_bytes;
   logic [CNT_W-1:0] byte_count;
   logic             last;

   modport source (output valid, out_bytes, byte_count, last, input ready);
   modport sink   (input valid, out_bytes, byte_count, last, output ready);
endinterface

/* design/lzwcd_window.sv */
// Byte-addressed history window: eight byte-wide banks, one read and one write
// of up to eight consecutive bytes per cycle at any alignment. Uses lzwcd_pkg.
module lzwcd_window import lzwcd_pkg::*; #(
   parameter int WINDOW_BITS = 14
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [WINDOW_BITS-1:0] rd_addr,
   output logic [OUT_W-1:0]       rd_data,
   input  logic                   wr_en,
   input  logic [WINDOW_BITS-1:0] wr_addr,
   input  logic [CNT_W-1:0]       wr_count,
   input  logic [OUT_W-1:0]       wr_data
);

   localparam int ROW_W = WINDOW_BITS - LANE_W;
   localparam int ROWS  = 2 ** ROW_W;

   logic [LANE_W-1:0] rd_lo_ff;
   logic [BYTE_W-1:0] bank_q [LANES];

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      logic [BYTE_W-1:0]      mem [ROWS];
      logic [BYTE_W-1:0]      q_ff;
      logic [LANE_W-1:0]      rd_i;
      logic [LANE_W-1:0]      wr_i;
      logic [WINDOW_BITS-1:0] rd_a;
      logic [WINDOW_BITS-1:0] wr_a;
      logic                   wr_be;

      // stream byte index that lands in this bank
      assign rd_i  = LANE_W'(b) - rd_addr[LANE_W-1:0];
      assign rd_a  = rd_addr + WINDOW_BITS'(rd_i);
      assign wr_i  = LANE_W'(b) - wr_addr[LANE_W-1:0];
      assign wr_a  = wr_addr + WINDOW_BITS'(wr_i);
      assign wr_be = wr_en && (CNT_W'(wr_i) < wr_count);

      // read returns the old contents on a same-row write
      always_ff @(posedge clock) begin
         if (rd_en) q_ff <= mem[rd_a[WINDOW_BITS-1:LANE_W]];
         if (wr_be) mem[wr_a[WINDOW_BITS-1:LANE_W]] <= wr_data[BYTE_W*wr_i +: BYTE_W];
      end

      assign bank_q[b] = q_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_lo_ff <= rd_addr[LANE_W-1:0];
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rd_data[i*BYTE_W +: BYTE_W] = bank_q[LANE_W'(rd_lo_ff + LANE_W'(i))];
      end
   end

endmodule

/* design/lzwcd_copy_buf.sv */
// Copy buffer: one 64-bit row per result beat of a match, for deferred
// write-back to the window. Registered read. Uses lzwcd_pkg.
module lzwcd_copy_buf import lzwcd_pkg::*; #(
   parameter  int DEPTH = 33,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [OUT_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [OUT_W-1:0] rd_data
);

   logic [OUT_W-1:0] mem [DEPTH];
   logic [OUT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lzss_window_copy_decoder.sv */
// LZSS window copy decoder, top level.
// Tokens arrive on req_chan; result beats of up to eight bytes leave on rsp_chan,
// first byte in bits 7:0, unused lanes zero, last set on a token's final beat.
// A literal gives one beat; a match gives ceil(len/8) beats, len clamped to
// MIN_MATCH .. 2^LENGTH_BITS+MIN_MATCH.
// After reset a clearing pass zeroes all 2^(WINDOW_BITS-3) window rows (2048 at
// default size), one row of all eight banks a cycle; req_chan is not ready
// during it.
// A literal beat passes the literal byte register, then the output register;
// a match enters ST_MATCH, then each beat passes the window's read register
// and the output register. Literals are taken one per cycle while the
// receiver takes beats; a match reads through the one 8-byte window read port.
// When the source trails the write pointer by 9 to len-1 bytes, or len exceeds
// the window, the copied bytes are written back from the copy buffer afterwards.
// Receiver stall: an output register and a second stage (the window's read
// register) hold two beats; reads stop until the receiver takes a beat.
// A new token is taken while one beat still waits in the output register.
module lzss_window_copy_decoder import lzwcd_pkg::*; #(
   parameter int WINDOW_BITS = 14,
   parameter int LENGTH_BITS = 8,
   parameter int MIN_MATCH   = 3
) (
   input logic         clock,
   input logic         reset,
   lzwcd_req_if.sink   req_chan,
   lzwcd_rsp_if.source rsp_chan
);

   localparam int W        = WINDOW_BITS;
   localparam int WIN_SIZE = 2 ** W;
   localparam int ROW_W    = W - LANE_W;
   localparam int MAX_LEN  = 2 ** LENGTH_BITS + MIN_MATCH;
   localparam int OFF_W    = $clog2(MAX_LEN + LANES + 1);
   localparam int NCH      = (MAX_LEN + LANES - 1) / LANES;
   localparam int BUF_AW   = $clog2(NCH);

   state_type state_ff, state_in;

   logic [W-1:0]      wp_ff, wp_in;
   logic [ROW_W-1:0]  clr_row_ff, clr_row_in;
   logic [W-1:0]      pos_ff, pos_in;
   logic [OFF_W-1:0]  len_ff, len_in;
   logic [OFF_W-1:0]  rd_off_ff, rd_off_in;
   logic [OFF_W-1:0]  wr_off_ff, wr_off_in;
   logic              fast_ff, fast_in;
   logic              pend_ff, pend_in;
   logic              pend_lit_ff, pend_lit_in;
   logic              pend_last_ff, pend_last_in;
   logic [CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic [BYTE_W-1:0] lit_byte_ff, lit_byte_in;
   logic              wbv_ff, wbv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  out_bytes_ff, out_bytes_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic              last_ff, last_in;

   logic              out_free, load, issue, accept, ready;
   logic              rd_more, match_end, wb_issue, wb_end;
   logic [OFF_W-1:0]  rd_rem, wr_rem, len_eff;
   logic [CNT_W-1:0]  rd_cnt, wb_cnt;
   logic [W-1:0]      pos_eff, lag;
   logic              fast_eff;
   logic [OUT_W-1:0]  pend_word;

   logic              win_rd_en;
   logic [W-1:0]      win_rd_addr;
   logic [OUT_W-1:0]  win_rd_data;
   logic              win_wr_en;
   logic [W-1:0]      win_wr_addr;
   logic [CNT_W-1:0]  win_wr_count;
   logic [OUT_W-1:0]  win_wr_data;
   logic              buf_wr_en, buf_rd_en;
   logic [BUF_AW-1:0] buf_wr_addr, buf_rd_addr;
   logic [OUT_W-1:0]  buf_rd_data;

   lzwcd_window #(.WINDOW_BITS(W)) u_window (
      .clock    (clock),
      .rd_en    (win_rd_en),
      .rd_addr  (win_rd_addr),
      .rd_data  (win_rd_data),
      .wr_en    (win_wr_en),
      .wr_addr  (win_wr_addr),
      .wr_count (win_wr_count),
      .wr_data  (win_wr_data)
   );

   lzwcd_copy_buf #(.DEPTH(NCH)) u_copy_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (pend_word),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // ---- datapath terms ----
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign load     = pend_ff && out_free;
   assign rd_rem   = len_ff - rd_off_ff;
   assign wr_rem   = len_ff - wr_off_ff;
   assign rd_more  = rd_off_ff < len_ff;
   assign rd_cnt   = (rd_rem >= OFF_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(rd_rem);
   assign wb_cnt   = (wr_rem >= OFF_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(wr_rem);
   assign accept   = req_chan.valid && ready;

   assign issue     = (state_ff == ST_MATCH) && rd_more && (!pend_ff || load);
   assign match_end = (state_ff == ST_MATCH) && load && pend_last_ff;
   assign wb_issue  = (state_ff == ST_WRITEBACK) && rd_more;
   assign wb_end    = (state_ff == ST_WRITEBACK) && wbv_ff && (wr_rem <= OFF_W'(LANES));

   assign pend_word = pend_lit_ff ? OUT_W'(lit_byte_ff)
                                  : (win_rd_data & lane_mask(pend_cnt_ff));

   assign pos_eff = W'(req_chan.match_pos);
   assign lag     = wp_ff - pos_eff;

   always_comb begin
      if (int'(req_chan.match_len) < MIN_MATCH) begin
         len_eff = OFF_W'(MIN_MATCH);
      end else if (int'(req_chan.match_len) > MAX_LEN) begin
         len_eff = OFF_W'(MAX_LEN);
      end else begin
         len_eff = OFF_W'(req_chan.match_len);
      end
   end

   // Writes may follow reads beat by beat unless a write lands on source bytes
   // still to be read two or more beats later.
   assign fast_eff = (int'(len_eff) <= WIN_SIZE) &&
                     ((int'(lag) <= LANES) || (int'(lag) >= int'(len_eff)));

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && (req_chan.action == ACT_MATCH)) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            if (match_end) state_in = fast_ff ? ST_IDLE : ST_WRITEBACK;
         end
         ST_WRITEBACK: begin
            if (wb_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- memory ports and handshake ----
   always_comb begin
      ready        = 1'b0;
      win_wr_en    = 1'b0;
      win_wr_addr  = wp_ff + W'(wr_off_ff);
      win_wr_count = pend_cnt_ff;
      win_wr_data  = pend_word;
      buf_wr_en    = 1'b0;
      buf_rd_en    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            win_wr_en    = 1'b1;
            win_wr_addr  = {clr_row_ff, LANE_W'(0)};
            win_wr_count = CNT_W'(LANES);
            win_wr_data  = '0;
         end
         ST_IDLE: begin
            ready        = !pend_ff || load;
            win_wr_en    = accept && (req_chan.action == ACT_LITERAL);
            win_wr_addr  = wp_ff;
            win_wr_count = CNT_W'(1);
            win_wr_data  = OUT_W'(req_chan.literal_byte);
         end
         ST_MATCH: begin
            win_wr_en = load && fast_ff;
            buf_wr_en = load && !fast_ff;
         end
         ST_WRITEBACK: begin
            win_wr_en    = wbv_ff;
            win_wr_count = wb_cnt;
            win_wr_data  = buf_rd_data;
            buf_rd_en    = wb_issue;
         end
         default: ready = 1'b0;
      endcase
   end

   assign win_rd_en   = issue;
   assign win_rd_addr = pos_ff + W'(rd_off_ff);
   assign buf_wr_addr = BUF_AW'(wr_off_ff >> LANE_W);
   assign buf_rd_addr = BUF_AW'(rd_off_ff >> LANE_W);

   // ---- register next values ----
   always_comb begin
      wp_in         = wp_ff;
      clr_row_in    = clr_row_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      rd_off_in     = rd_off_ff;
      wr_off_in     = wr_off_ff;
      fast_in       = fast_ff;
      pend_in       = pend_ff;
      pend_lit_in   = pend_lit_ff;
      pend_last_in  = pend_last_ff;
      pend_cnt_in   = pend_cnt_ff;
      lit_byte_in   = lit_byte_ff;
      wbv_in        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_bytes_in  = out_bytes_ff;
      byte_count_in = byte_count_ff;
      last_in       = last_ff;

      if (state_ff == ST_CLEAR) clr_row_in = clr_row_ff + ROW_W'(1);

      if (load) begin
         pend_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         out_bytes_in  = pend_word;
         byte_count_in = pend_cnt_ff;
         last_in       = pend_last_ff;
      end

      if (accept) begin
         if (req_chan.action == ACT_LITERAL) begin
            wp_in        = wp_ff + W'(1);
            pend_in      = 1'b1;
            pend_lit_in  = 1'b1;
            pend_last_in = 1'b1;
            pend_cnt_in  = CNT_W'(1);
            lit_byte_in  = req_chan.literal_byte;
         end else begin
            pos_in    = pos_eff;
            len_in    = len_eff;
            fast_in   = fast_eff;
            rd_off_in = '0;
            wr_off_in = '0;
         end
      end

      if (issue) begin
         pend_in      = 1'b1;
         pend_lit_in  = 1'b0;
         pend_cnt_in  = rd_cnt;
         pend_last_in = rd_rem <= OFF_W'(LANES);
         rd_off_in    = rd_off_ff + OFF_W'(LANES);
      end

      if ((state_ff == ST_MATCH) && load) begin
         wr_off_in = wr_off_ff + OFF_W'(LANES);
         if (pend_last_ff) begin
            if (fast_ff) begin
               wp_in = wp_ff + W'(len_ff);
            end else begin
               rd_off_in = '0;
               wr_off_in = '0;
            end
         end
      end

      if (wb_issue) begin
         rd_off_in = rd_off_ff + OFF_W'(LANES);
         wbv_in    = 1'b1;
      end
      if ((state_ff == ST_WRITEBACK) && wbv_ff) wr_off_in = wr_off_ff + OFF_W'(LANES);
      if (wb_end) wp_in = wp_ff + W'(len_ff);
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         clr_row_ff   <= '0;
         pend_ff      <= 1'b0;
         wbv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         clr_row_ff   <= clr_row_in;
         pend_ff      <= pend_in;
         wbv_ff       <= wbv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      len_ff        <= len_in;
      rd_off_ff     <= rd_off_in;
      wr_off_ff     <= wr_off_in;
      fast_ff       <= fast_in;
      pend_lit_ff   <= pend_lit_in;
      pend_last_ff  <= pend_last_in;
      pend_cnt_ff   <= pend_cnt_in;
      lit_byte_ff   <= lit_byte_in;
      out_bytes_ff  <= out_bytes_in;
      byte_count_ff <= byte_count_in;
      last_ff       <= last_in;
   end

   assign req_chan.ready      = ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_bytes  = out_bytes_ff;
   assign rsp_chan.byte_count = byte_count_ff;
   assign rsp_chan.last       = last_ff;

endmodule

/* tb/sv/tb_lzss_window_copy_decoder.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lzss_window_copy_decoder: token beats in, byte beats out.
// Depends on lzwcd_pkg and the lzwcd_req_if / lzwcd_rsp_if channel interfaces.
module tb_lzss_window_copy_decoder;
   import lzwcd_pkg::*;

   localparam int WIN_BITS      = 14;
   localparam int LENGTH_BITS   = 8;
   localparam int MIN_MATCH     = 3;
   localparam int WIN_SIZE      = 1 << WIN_BITS;
   localparam int MAX_LEN       = (1 << LENGTH_BITS) + MIN_MATCH;
   localparam int RANDOM_TOKENS = 170;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 64;
   localparam int CYCLE_LIMIT   = 300000;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] lit;
      logic [POS_W-1:0]  pos;
      logic [LEN_W-1:0]  len;
   } token_type;

   typedef struct packed {
      logic [OUT_W-1:0] data;
      logic [CNT_W-1:0] cnt;
      logic             last;
   } out_beat_type;

   // rel: pos is an offset back from the write pointer
   // typed: the single result beat is given in the row
   typedef struct {
      token_type    tok;
      bit           rel;
      bit           typed;
      out_beat_type want;
   } table_row_type;

   logic clock;
   logic reset;

   lzwcd_req_if req_chan ();
   lzwcd_rsp_if rsp_chan ();

   lzss_window_copy_decoder #(
      .WINDOW_BITS(WIN_BITS),
      .LENGTH_BITS(LENGTH_BITS),
      .MIN_MATCH  (MIN_MATCH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   logic [BYTE_W-1:0] window_shadow [0:WIN_SIZE-1];
   logic [POS_W-1:0]  shadow_wr_ptr;
   out_beat_type      token_beats [$];
   out_beat_type      pending_beats [$];
   table_row_type     directed_rows [$];

   int  error_count = 0;
   int  beat_index  = 0;
   int  cycle_count = 0;
   int  burst_left  = 0;
   int  steady_left = 0;
   bit  hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL lzss_window_copy_decoder");
      $finish;
   end

   // Shadow of the window: a match reads all its bytes before writing any.
   function automatic void decode_token(input token_type t);
      logic [BYTE_W-1:0] copy_buf [MAX_LEN];
      int                n;
      int                take;
      out_beat_type      b;
      token_beats.delete();
      if (t.action == ACT_LITERAL) begin
         window_shadow[shadow_wr_ptr] = t.lit;
         shadow_wr_ptr = shadow_wr_ptr + 1'b1;
         b.data = '0;
         b.data[BYTE_W-1:0] = t.lit;
         b.cnt  = CNT_W'(1);
         b.last = 1'b1;
         token_beats.push_back(b);
      end else begin
         n = int'(t.len);
         if (n < MIN_MATCH) n = MIN_MATCH;
         if (n > MAX_LEN) n = MAX_LEN;
         for (int i = 0; i < n; i++) copy_buf[i] = window_shadow[POS_W'(int'(t.pos) + i)];
         for (int i = 0; i < n; i++)
            window_shadow[POS_W'(int'(shadow_wr_ptr) + i)] = copy_buf[i];
         shadow_wr_ptr = POS_W'(int'(shadow_wr_ptr) + n);
         for (int done = 0; done < n; done += LANES) begin
            take = (n - done > LANES) ? LANES : n - done;
            b.data = '0;
            for (int j = 0; j < take; j++) b.data[j*BYTE_W +: BYTE_W] = copy_buf[done + j];
            b.cnt  = CNT_W'(take);
            b.last = (done + take >= n);
            token_beats.push_back(b);
         end
      end
   endfunction

   function automatic void add_row(input logic act, input int lit, input int pos, input int len,
                                   input bit rel, input bit typed, input int want_data,
                                   input int want_cnt);
      table_row_type r;
      r.tok.action   = act;
      r.tok.lit      = BYTE_W'(lit);
      r.tok.pos      = POS_W'(pos);
      r.tok.len      = LEN_W'(len);
      r.rel          = rel;
      r.typed        = typed;
      r.want.data    = OUT_W'(want_data);
      r.want.cnt     = CNT_W'(want_cnt);
      r.want.last    = 1'b1;
      directed_rows.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                  input logic [OUT_W-1:0] got);
      error_count++;
      $display("mismatch %s, result beat %0d at %0t: expected %h, got %h",
               what, beat_index, $time, want, got);
   endtask

   // Called at a rising edge; returns at the edge where the beat is taken.
   task automatic offer_token(input token_type t, input bit typed, input out_beat_type want);
      bit taken;
      req_chan.valid        <= 1'b1;
      req_chan.action       <= t.action;
      req_chan.literal_byte <= t.lit;
      req_chan.match_pos    <= t.pos;
      req_chan.match_len    <= t.len;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end
      decode_token(t);
      if (typed) pending_beats.push_back(want);
      else foreach (token_beats[i]) pending_beats.push_back(token_beats[i]);
   endtask

   task automatic pace_sender();
      int gap;
      if (steady_left > 0) begin
         steady_left--;
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = $urandom_range(0, 9);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin : token_source
      token_type    t;
      out_beat_type none;
      int           sel;
      none = '0;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.action       <= ACT_LITERAL;
      req_chan.literal_byte <= '0;
      req_chan.match_pos    <= '0;
      req_chan.match_len    <= '0;
      for (int i = 0; i < WIN_SIZE; i++) window_shadow[i] = '0;
      shadow_wr_ptr = '0;

      // window is all zero after reset; short lengths clamp up
      add_row(ACT_MATCH,   8'h3C, 0,     0,   1'b0, 1'b1, 0,     3);
      add_row(ACT_MATCH,   8'hC3, 16383, 2,   1'b0, 1'b1, 0,     3);
      add_row(ACT_LITERAL, 8'h00, 16383, 511, 1'b0, 1'b1, 8'h00, 1);
      add_row(ACT_LITERAL, 8'hFF, 0,     0,   1'b0, 1'b1, 8'hFF, 1);
      add_row(ACT_LITERAL, 8'hA5, 5,     7,   1'b0, 1'b1, 8'hA5, 1);
      add_row(ACT_LITERAL, 8'h5A, 9,     300, 1'b0, 1'b1, 8'h5A, 1);
      add_row(ACT_MATCH,   8'hFF, 4,     4,   1'b1, 1'b0, 0, 0);
      // source trailing the write pointer: old bytes only, no feedback
      add_row(ACT_MATCH,   8'h00, 1,     20,  1'b1, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 9,     30,  1'b1, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 16,    40,  1'b1, 1'b0, 0, 0);
      // source just ahead of the write pointer
      add_row(ACT_MATCH,   8'h00, 16382, 24,  1'b1, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 0,     259, 1'b0, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 100,   260, 1'b0, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 16383, 511, 1'b0, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 3,     8,   1'b1, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 5,     9,   1'b1, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 200,   16,  1'b1, 1'b0, 0, 0);
      add_row(ACT_LITERAL, 8'h01, 16383, 0,   1'b0, 1'b1, 8'h01, 1);
      add_row(ACT_LITERAL, 8'h80, 0,     511, 1'b0, 1'b1, 8'h80, 1);
      add_row(ACT_MATCH,   8'h00, 1,     3,   1'b1, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 16380, 10,  1'b0, 1'b0, 0, 0);
      // source equal to destination, then trailing it by exactly the length
      add_row(ACT_MATCH,   8'h00, 0,     17,  1'b1, 1'b0, 0, 0);
      add_row(ACT_MATCH,   8'h00, 259,   259, 1'b1, 1'b0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         t = directed_rows[i].tok;
         if (directed_rows[i].rel) t.pos = shadow_wr_ptr - directed_rows[i].tok.pos;
         offer_token(t, directed_rows[i].typed, directed_rows[i].want);
         pace_sender();
      end

      for (int n = 0; n < RANDOM_TOKENS; n++) begin
         t.action = ($urandom_range(0, 99) < 30) ? ACT_LITERAL : ACT_MATCH;
         t.lit    = BYTE_W'($urandom);
         t.pos    = POS_W'($urandom);
         t.len    = LEN_W'($urandom);
         if (t.action == ACT_MATCH) begin
            // long lengths dominate the byte count so the write pointer wraps
            sel = $urandom_range(0, 9);
            if (sel < 4) t.len = LEN_W'($urandom_range(200, 511));
            else if (sel < 9) t.len = LEN_W'($urandom_range(0, 40));
            sel = $urandom_range(0, 9);
            if (sel >= 8) t.pos = shadow_wr_ptr + POS_W'($urandom_range(0, 300));
            else if (sel >= 4) t.pos = shadow_wr_ptr - POS_W'($urandom_range(1, 300));
         end
         offer_token(t, 1'b0, none);
         if (n == 50) begin
            // receiver holds off while the sender keeps pushing
            hold_request = 1'b1;
            steady_left  = 40;
         end
         pace_sender();
         if (n == 110) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (pending_beats.size() != 0) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS lzss_window_copy_decoder");
      end else begin
         $display("FAIL lzss_window_copy_decoder");
      end
      $finish;
   end

   initial begin : result_sink
      int phase_left;
      int mode;
      int tick;
      phase_left = 0;
      mode       = 0;
      tick       = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(20, 200);
               mode       = $urandom_range(0, 3);
            end
            phase_left--;
            tick++;
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= (tick % 4 == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 99) < 85);
            endcase
         end
      end
   end

   // Sampled mid-cycle: the beat is taken at the next rising edge.
   always @(negedge clock) begin : result_check
      out_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat", '0, rsp_chan.out_bytes);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_chan.out_bytes !== want.data)
               report_mismatch("out_bytes", want.data, rsp_chan.out_bytes);
            if (rsp_chan.byte_count !== want.cnt)
               report_mismatch("byte_count", OUT_W'(want.cnt), OUT_W'(rsp_chan.byte_count));
            if (rsp_chan.last !== want.last)
               report_mismatch("last", OUT_W'(want.last), OUT_W'(rsp_chan.last));
         end
         beat_index++;
      end
   end

endmodule

/* files.f */
design/lzwcd_pkg.sv
design/lzwcd_if.sv
design/lzwcd_window.sv
design/lzwcd_copy_buf.sv
design/lzss_window_copy_decoder.sv
tb/sv/tb_lzss_window_copy_decoder.sv
